@@ rtl/sfa_pkg.sv @@
// ----------------------------------------------------------------------------
// sfa_pkg: shared types and constants of the sprite frame animator
// Configuration layout, divider request/response, result record, sequencer
// states.
// ----------------------------------------------------------------------------
package sfa_pkg;

  localparam int unsigned TIMER_W    = 32;
  localparam int unsigned FRAME_W    = 16;
  localparam int unsigned FPS_W      = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Shared divider: 33-bit dividend, 32-bit divisor, one quotient bit a cycle
  localparam int unsigned DIV_NW = 33;
  localparam int unsigned DIV_DW = 32;
  localparam int unsigned DIV_CW = 6;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_VALID    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_FRAME   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FPS           = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHEET_COLUMNS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT   = 3'd7;

  typedef struct packed {
    logic               clip_valid;
    logic [FRAME_W-1:0] first_frame;
    logic [FRAME_W-1:0] frame_count;
    logic [FPS_W-1:0]   fps;
    logic               loop_enable;
    logic [FRAME_W-1:0] sheet_columns;
    logic [FRAME_W-1:0] cell_width;
    logic [FRAME_W-1:0] cell_height;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_NW-1:0] quot;
    logic [DIV_DW-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic signed [FRAME_W-1:0] src_x;
    logic signed [FRAME_W-1:0] src_y;
    logic signed [FRAME_W-1:0] src_w;
    logic signed [FRAME_W-1:0] src_h;
    logic [FRAME_W-1:0]        clip_frame;
    logic                      done_res;
  } rect_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD,
    ST_DUR,
    ST_STEP,
    ST_FRAME,
    ST_RECT,
    ST_COL,
    ST_MULX,
    ST_MULY,
    ST_DONE
  } st_e;

endpackage

@@ rtl/sprite_frame_animator_core.sv @@
// ----------------------------------------------------------------------------
// sprite_frame_animator_core: sprite-sheet frame animator
// Advances a clip's frame by elapsed time and reports the sheet rectangle of
// the current frame, one result beat per tick beat.
// ----------------------------------------------------------------------------
// Each tick beat carries an elapsed time in unsigned fixed point (FRAC_BITS
// fraction bits) and yields exactly one result beat: the source rectangle, the
// frame number within the clip and the finished flag. After a tick beat is
// taken, in_ready_o stays low until the sequencer is back in idle: an invalid
// clip goes straight to its result; otherwise the tick runs through the
// shared 33-step restoring divider, used up to four times per tick: frame
// duration, durations elapsed, loop wrap, and sheet row/column. in_ready_o
// is high only while the sequencer is idle. A result sits in the output
// register until taken, so the next tick is accepted while it waits; a
// second result that finds the register still full holds the sequencer in
// its last state, and ready stays low, until the first is taken.
// Configuration writes are registered and are meant for idle periods; they
// never reset the timer, frame number or finished flag.
// ----------------------------------------------------------------------------
module sprite_frame_animator_core #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // tick channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [sfa_pkg::TIMER_W-1:0]          elapsed_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [sfa_pkg::FRAME_W-1:0]   src_x_o,
  output logic signed [sfa_pkg::FRAME_W-1:0]   src_y_o,
  output logic signed [sfa_pkg::FRAME_W-1:0]   src_w_o,
  output logic signed [sfa_pkg::FRAME_W-1:0]   src_h_o,
  output logic [sfa_pkg::FRAME_W-1:0]          clip_frame_o,
  output logic                                 done_res_o,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [sfa_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [sfa_pkg::CFG_DATA_W-1:0]       cfg_wdata_i
);
  import sfa_pkg::*;

  cfg_t      cfg_q, cfg_d;
  logic      out_valid_q, out_valid_d;
  rect_res_t out_q, out_d;
  rect_res_t eng_res;
  logic      eng_idle;
  logic      eng_valid;
  logic      res_ack;
  logic      tick_accept;

  // Register file: decode the index, mask data to the register width
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CLIP_VALID:    cfg_d.clip_valid    = cfg_wdata_i[0];
        REG_FIRST_FRAME:   cfg_d.first_frame   = cfg_wdata_i;
        REG_FRAME_COUNT:   cfg_d.frame_count   = cfg_wdata_i;
        REG_FPS:           cfg_d.fps           = cfg_wdata_i[FPS_W-1:0];
        REG_LOOP_ENABLE:   cfg_d.loop_enable   = cfg_wdata_i[0];
        REG_SHEET_COLUMNS: cfg_d.sheet_columns = cfg_wdata_i;
        REG_CELL_WIDTH:    cfg_d.cell_width    = cfg_wdata_i;
        REG_CELL_HEIGHT:   cfg_d.cell_height   = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{sheet_columns: FRAME_W'(1), default: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign tick_accept = in_valid_i && in_ready_o;
  assign in_ready_o  = eng_idle;

  sfa_engine #(
    .FRAC_BITS (FRAC_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (tick_accept),
    .elapsed_i   (elapsed_i),
    .cfg_i       (cfg_q),
    .res_ack_i   (res_ack),
    .idle_o      (eng_idle),
    .res_valid_o (eng_valid),
    .res_o       (eng_res)
  );

  // Output register: load when empty or being drained, hold otherwise
  assign res_ack = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_ack) begin
      out_valid_d = eng_valid;
      if (eng_valid) out_d = eng_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o  = out_valid_q;
  assign src_x_o      = out_q.src_x;
  assign src_y_o      = out_q.src_y;
  assign src_w_o      = out_q.src_w;
  assign src_h_o      = out_q.src_h;
  assign clip_frame_o = out_q.clip_frame;
  assign done_res_o   = out_q.done_res;

  a_busy_after_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_accept |=> !in_ready_o)
    else $error("ready stayed high after a tick beat");

endmodule

@@ rtl/sfa_div.sv @@
// ----------------------------------------------------------------------------
// sfa_div: shared restoring divider
// Unsigned 33-by-32 bit division, one quotient bit per cycle; result holds
// until the next start.
// ----------------------------------------------------------------------------
module sfa_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sfa_pkg::div_req_t   req_i,
  output sfa_pkg::div_rsp_t   rsp_o
);
  import sfa_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DIV_CW-1:0] cnt_q, cnt_d;
  logic [DIV_NW-1:0] quo_q, quo_d;
  logic [DIV_DW-1:0] rem_q, rem_d;
  logic [DIV_DW-1:0] dvs_q, dvs_d;
  logic [DIV_DW:0]   trial;
  logic [DIV_DW:0]   diff;

  always_comb begin
    trial  = {rem_q, quo_q[DIV_NW-1]};
    diff   = trial - {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CW'(DIV_NW);
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      // subtract when the shifted partial remainder covers the divisor
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = diff[DIV_DW-1:0];
        quo_d = {quo_q[DIV_NW-2:0], 1'b1};
      end else begin
        rem_d = trial[DIV_DW-1:0];
        quo_d = {quo_q[DIV_NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - DIV_CW'(1);
      if (cnt_q == DIV_CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

@@ rtl/sfa_engine.sv @@
// ----------------------------------------------------------------------------
// sfa_engine: tick sequencer and animation state
// Runs one tick through the shared divider and a 16x16 multiplier; owns the
// frame timer, frame number, finished latch and held rectangle.
// ----------------------------------------------------------------------------
module sfa_engine #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [sfa_pkg::TIMER_W-1:0]       elapsed_i,
  input  sfa_pkg::cfg_t                     cfg_i,
  input  logic                              res_ack_i,
  output logic                              idle_o,
  output logic                              res_valid_o,
  output sfa_pkg::rect_res_t                res_o
);
  import sfa_pkg::*;

  localparam logic [DIV_NW-1:0] DUR_NUM = DIV_NW'(1) << FRAC_BITS;

  st_e                st_q, st_d;
  logic [TIMER_W-1:0] dt_q, dt_d;
  logic [TIMER_W-1:0] timer_q, timer_d;
  logic [FRAME_W-1:0] fn_q, fn_d;
  logic               fin_q, fin_d;
  logic [FRAME_W-1:0] rx_q, rx_d, ry_q, ry_d, rw_q, rw_d, rh_q, rh_d;

  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic               adv_en;
  logic [TIMER_W:0]   sum;
  logic [TIMER_W-1:0] sat;
  logic [DIV_DW-1:0]  dur;
  logic [TIMER_W-1:0] steps;
  logic               not_last;
  logic [FRAME_W-1:0] to_last;
  logic               fits;
  logic [DIV_NW-1:0]  wrap_num;
  logic [FRAME_W-1:0] f_cl;
  logic [FRAME_W-1:0] gidx;
  logic [FRAME_W-1:0] cols;
  logic [FRAME_W-1:0] mul_a, mul_b;
  logic [2*FRAME_W-1:0] prod;

  sfa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Shared helpers
  always_comb begin
    adv_en   = (cfg_i.fps != '0) && (cfg_i.frame_count > FRAME_W'(1)) &&
               !(fin_q && !cfg_i.loop_enable);
    sum      = {1'b0, timer_q} + {1'b0, dt_q};
    sat      = sum[TIMER_W] ? '1 : sum[TIMER_W-1:0];
    dur      = (div_rsp.quot == '0) ? DIV_DW'(1) : div_rsp.quot[DIV_DW-1:0];
    steps    = div_rsp.quot[TIMER_W-1:0];
    not_last = ({1'b0, fn_q} + 17'd1) < {1'b0, cfg_i.frame_count};
    to_last  = cfg_i.frame_count - FRAME_W'(1) - fn_q;
    fits     = steps <= {16'b0, to_last};
    wrap_num = not_last ? ({1'b0, steps} + {17'b0, fn_q})
                        : {1'b0, steps - TIMER_W'(1)};
    f_cl     = ((cfg_i.frame_count != '0) && (fn_q >= cfg_i.frame_count)) ?
               (cfg_i.frame_count - FRAME_W'(1)) : fn_q;
    gidx     = cfg_i.first_frame + f_cl;
    cols     = (cfg_i.sheet_columns == '0) ? FRAME_W'(1) : cfg_i.sheet_columns;
    mul_a    = (st_q == ST_MULX) ? div_rsp.rem[FRAME_W-1:0]
                                 : div_rsp.quot[FRAME_W-1:0];
    mul_b    = (st_q == ST_MULX) ? cfg_i.cell_width : cfg_i.cell_height;
    prod     = mul_a * mul_b;
  end

  // Next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: begin
        if (start_i) begin
          if (!cfg_i.clip_valid) st_d = ST_DONE;
          else if (adv_en)       st_d = ST_ADD;
          else                   st_d = ST_RECT;
        end
      end
      ST_ADD:  st_d = ST_DUR;
      ST_DUR: begin
        if (div_rsp.done) st_d = ST_STEP;
      end
      ST_STEP: begin
        if (div_rsp.done) begin
          if (steps != '0 && cfg_i.loop_enable) st_d = ST_FRAME;
          else                                  st_d = ST_RECT;
        end
      end
      ST_FRAME: begin
        if (div_rsp.done) st_d = ST_RECT;
      end
      ST_RECT: st_d = ST_COL;
      ST_COL: begin
        if (div_rsp.done) st_d = ST_MULX;
      end
      ST_MULX: st_d = ST_MULY;
      ST_MULY: st_d = ST_DONE;
      ST_DONE: begin
        if (res_ack_i) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // Outputs: divider requests and result handoff
  always_comb begin
    div_req     = '0;
    idle_o      = 1'b0;
    res_valid_o = 1'b0;
    unique case (st_q)
      ST_IDLE: idle_o = 1'b1;
      ST_ADD: begin
        div_req.start    = 1'b1;
        div_req.dividend = DUR_NUM;
        div_req.divisor  = {24'b0, cfg_i.fps};
      end
      ST_DUR: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = {1'b0, timer_q};
        div_req.divisor  = dur;
      end
      ST_STEP: begin
        div_req.start    = div_rsp.done && (steps != '0) && cfg_i.loop_enable;
        div_req.dividend = wrap_num;
        div_req.divisor  = {16'b0, cfg_i.frame_count};
      end
      ST_RECT: begin
        div_req.start    = 1'b1;
        div_req.dividend = {17'b0, gidx};
        div_req.divisor  = {16'b0, cols};
      end
      ST_DONE: res_valid_o = 1'b1;
      default: ;
    endcase
  end

  // Datapath
  always_comb begin
    dt_d    = dt_q;
    timer_d = timer_q;
    fn_d    = fn_q;
    fin_d   = fin_q;
    rx_d    = rx_q;
    ry_d    = ry_q;
    rw_d    = rw_q;
    rh_d    = rh_q;
    case (st_q)
      ST_IDLE: begin
        if (start_i) dt_d = elapsed_i;
      end
      ST_ADD: timer_d = sat;
      ST_STEP: begin
        if (div_rsp.done && steps != '0) begin
          if (cfg_i.loop_enable) begin
            timer_d = div_rsp.rem;
          end else if (not_last && fits) begin
            fn_d    = fn_q + steps[FRAME_W-1:0];
            timer_d = div_rsp.rem;
          end else begin
            // clamp on the last frame and stop
            if (not_last) fn_d = cfg_i.frame_count - FRAME_W'(1);
            fin_d   = 1'b1;
            timer_d = '0;
          end
        end
      end
      ST_FRAME: begin
        if (div_rsp.done) fn_d = div_rsp.rem[FRAME_W-1:0];
      end
      ST_MULX: rx_d = prod[FRAME_W-1:0];
      ST_MULY: begin
        ry_d = prod[FRAME_W-1:0];
        rw_d = cfg_i.cell_width;
        rh_d = cfg_i.cell_height;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      timer_q <= '0;
      fn_q    <= '0;
      fin_q   <= 1'b0;
      rx_q    <= '0;
      ry_q    <= '0;
      rw_q    <= '0;
      rh_q    <= '0;
    end else begin
      st_q    <= st_d;
      timer_q <= timer_d;
      fn_q    <= fn_d;
      fin_q   <= fin_d;
      rx_q    <= rx_d;
      ry_q    <= ry_d;
      rw_q    <= rw_d;
      rh_q    <= rh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dt_q <= dt_d;
  end

  assign res_o.src_x      = rx_q;
  assign res_o.src_y      = ry_q;
  assign res_o.src_w      = rw_q;
  assign res_o.src_h      = rh_q;
  assign res_o.clip_frame = fn_q;
  assign res_o.done_res   = fin_q;

  a_fin_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |=> fin_q)
    else $error("finished latch cleared");

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_IDLE && !start_i) |=> ($stable(timer_q) && $stable(fn_q)))
    else $error("animation state moved while idle");

  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

endmodule
